[design/fcc_pkg.sv]
// ----------------------------------------------------------------------------
// fcc_pkg
// shared types, constants and helpers for the frame clock and chronometer
// ----------------------------------------------------------------------------
package fcc_pkg;

   // width of the phase counter and the second prescaler
   localparam int TICK_COUNT_BITS = 8;
   // width of the ticks per second register
   localparam int TPS_BITS        = 8;
   // compare width wide enough for both counter and wrap value
   localparam int TICK_CMP_BITS   = (TICK_COUNT_BITS > TPS_BITS) ? TICK_COUNT_BITS : TPS_BITS;

   localparam int HOUR_BITS = 5;
   localparam int MIN_BITS  = 6;
   localparam int SEC_BITS  = 6;
   localparam int DATA_BITS = 8;

   // register indexes
   localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd0;
   localparam logic [1:0] REG_START_HOURS      = 2'd1;
   localparam logic [1:0] REG_START_MINUTES    = 2'd2;
   localparam logic [1:0] REG_START_SECONDS    = 2'd3;

   // timer modes
   localparam logic [1:0] MODE_FORWARDS  = 2'd0;
   localparam logic [1:0] MODE_BACKWARDS = 2'd1;
   localparam logic [1:0] MODE_STOPPED   = 2'd2;

   localparam logic [TPS_BITS-1:0] TPS_RESET = TPS_BITS'(50);

   typedef logic [TICK_COUNT_BITS-1:0] tick_type;

   typedef struct packed {
      logic [HOUR_BITS-1:0] hours;
      logic [MIN_BITS-1:0]  minutes;
      logic [SEC_BITS-1:0]  seconds;
   } hms_type;

   // counter step, back to zero once the wrap value is reached or passed
   function automatic tick_type tick_advance(input tick_type v,
                                             input logic [TPS_BITS-1:0] wrap);
      tick_type n;
      n = v + tick_type'(1);
      if (TICK_CMP_BITS'(n) >= TICK_CMP_BITS'(wrap)) begin
         return '0;
      end
      return n;
   endfunction

   // one second forward with 60/60/24 wraps
   function automatic hms_type hms_advance(input hms_type t);
      hms_type              r;
      logic [SEC_BITS:0]    s;
      logic [MIN_BITS:0]    m;
      logic [HOUR_BITS:0]   h;
      r = t;
      s = {1'b0, t.seconds} + 7'd1;
      m = {1'b0, t.minutes} + 7'd1;
      h = {1'b0, t.hours} + 6'd1;
      if (s >= 7'd60) begin
         r.seconds = '0;
         if (m >= 7'd60) begin
            r.minutes = '0;
            r.hours   = (h >= 6'd24) ? '0 : h[HOUR_BITS-1:0];
         end else begin
            r.minutes = m[MIN_BITS-1:0];
         end
      end else begin
         r.seconds = s[SEC_BITS-1:0];
      end
      return r;
   endfunction

endpackage

[design/frame_clock_and_chronometer.sv]
// ----------------------------------------------------------------------------
// frame_clock_and_chronometer
// frame-tick time-of-day clock with stopwatch / countdown timer
// ----------------------------------------------------------------------------
// Takes one frame tick per clock cycle while results are taken, and returns
// one result per tick carrying the clock, the timer and the timer mode as
// they stand after that tick. A tick lands in the input register, and one
// pass of counter logic then updates the state registers, which are also
// the result register. While a result waits to be taken the input register
// still holds one more tick, then req_ready drops until the result goes.
// Configuration writes complete at once (csr_ready is always high) and are
// meant for idle periods; the start time is loaded on the first unheld tick
// after reset.
// ----------------------------------------------------------------------------
module frame_clock_and_chronometer (
   input  logic                            clock,
   input  logic                            reset,
   // tick channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_held,
   input  logic                            req_button_pressed,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [fcc_pkg::HOUR_BITS-1:0]   rsp_clock_hours,
   output logic [fcc_pkg::MIN_BITS-1:0]    rsp_clock_minutes,
   output logic [fcc_pkg::SEC_BITS-1:0]    rsp_clock_seconds,
   output logic [fcc_pkg::HOUR_BITS-1:0]   rsp_timer_hours,
   output logic [fcc_pkg::MIN_BITS-1:0]    rsp_timer_minutes,
   output logic [fcc_pkg::SEC_BITS-1:0]    rsp_timer_seconds,
   output logic [1:0]                      rsp_timer_mode,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [fcc_pkg::DATA_BITS-1:0]   csr_wdata
);

   // configuration registers
   logic [fcc_pkg::TPS_BITS-1:0]  tps_ff;
   logic [fcc_pkg::HOUR_BITS-1:0] start_hours_ff;
   logic [fcc_pkg::MIN_BITS-1:0]  start_minutes_ff;
   logic [fcc_pkg::SEC_BITS-1:0]  start_seconds_ff;

   // input register
   logic in_valid_ff;
   logic held_ff;
   logic button_ff;

   // state, doubling as the result register
   fcc_pkg::tick_type phase_ff,     phase_in;
   fcc_pkg::tick_type prescale_ff,  prescale_in;
   fcc_pkg::hms_type  clock_ff,     clock_in;
   fcc_pkg::hms_type  timer_ff,     timer_in;
   logic [1:0]        mode_ff,      mode_in;
   logic              started_ff,   started_in;
   logic              rsp_valid_ff;

   logic fire;

   // a tick moves into the state when the result slot is free or emptying
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // configuration
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff           <= fcc_pkg::TPS_RESET;
         start_hours_ff   <= '0;
         start_minutes_ff <= '0;
         start_seconds_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            fcc_pkg::REG_TICKS_PER_SECOND: begin
               tps_ff <= csr_wdata[fcc_pkg::TPS_BITS-1:0];
            end
            fcc_pkg::REG_START_HOURS: begin
               start_hours_ff <= csr_wdata[fcc_pkg::HOUR_BITS-1:0];
            end
            fcc_pkg::REG_START_MINUTES: begin
               start_minutes_ff <= csr_wdata[fcc_pkg::MIN_BITS-1:0];
            end
            fcc_pkg::REG_START_SECONDS: begin
               start_seconds_ff <= csr_wdata[fcc_pkg::SEC_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         held_ff   <= req_held;
         button_ff <= req_button_pressed;
      end
   end

   // ---------------------------------------------------------------------
   // tick logic
   // ---------------------------------------------------------------------
   always_comb begin
      fcc_pkg::hms_type load_clock;
      logic [1:0]       pressed_mode;
      fcc_pkg::hms_type pressed_timer;

      // phase counter runs even on held ticks
      phase_in    = fcc_pkg::tick_advance(phase_ff, tps_ff);
      prescale_in = prescale_ff;
      clock_in    = clock_ff;
      timer_in    = timer_ff;
      mode_in     = mode_ff;
      started_in  = started_ff;

      // start time replaces the clock on the first unheld tick
      load_clock = started_ff ? clock_ff
                              : fcc_pkg::hms_type'{hours: start_hours_ff,
                                                   minutes: start_minutes_ff,
                                                   seconds: start_seconds_ff};

      // mode button: forwards goes backwards with minutes and hours cleared,
      // stopped (or the unused code) goes forwards, backwards ignores it
      pressed_mode  = mode_ff;
      pressed_timer = timer_ff;
      if (button_ff) begin
         if (mode_ff == fcc_pkg::MODE_FORWARDS) begin
            pressed_mode          = fcc_pkg::MODE_BACKWARDS;
            pressed_timer.minutes = '0;
            pressed_timer.hours   = '0;
         end else if (mode_ff != fcc_pkg::MODE_BACKWARDS) begin
            pressed_mode = fcc_pkg::MODE_FORWARDS;
         end
      end

      if (!held_ff) begin
         started_in = 1'b1;
         clock_in   = load_clock;
         timer_in   = pressed_timer;
         mode_in    = pressed_mode;

         // countdown: stops at zero, no borrow into minutes
         if (pressed_mode == fcc_pkg::MODE_BACKWARDS) begin
            if (pressed_timer.seconds <= fcc_pkg::SEC_BITS'(1)) begin
               timer_in.seconds = '0;
               mode_in          = fcc_pkg::MODE_STOPPED;
            end else if (phase_in != '0) begin
               timer_in.seconds = pressed_timer.seconds - fcc_pkg::SEC_BITS'(1);
            end
         end

         // second boundary
         prescale_in = fcc_pkg::tick_advance(prescale_ff, tps_ff);
         if (prescale_in == '0) begin
            clock_in = fcc_pkg::hms_advance(load_clock);
            if (mode_in == fcc_pkg::MODE_FORWARDS) begin
               timer_in = fcc_pkg::hms_advance(timer_in);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // state and result register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         prescale_ff  <= '0;
         clock_ff     <= '0;
         timer_ff     <= '0;
         mode_ff      <= fcc_pkg::MODE_FORWARDS;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff    <= phase_in;
            prescale_ff <= prescale_in;
            clock_ff    <= clock_in;
            timer_ff    <= timer_in;
            mode_ff     <= mode_in;
            started_ff  <= started_in;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_clock_hours   = clock_ff.hours;
   assign rsp_clock_minutes = clock_ff.minutes;
   assign rsp_clock_seconds = clock_ff.seconds;
   assign rsp_timer_hours   = timer_ff.hours;
   assign rsp_timer_minutes = timer_ff.minutes;
   assign rsp_timer_seconds = timer_ff.seconds;
   assign rsp_timer_mode    = mode_ff;

`ifndef SYNTH
   // a held tick leaves clock, timer and mode untouched
   assert property (@(posedge clock) disable iff (reset)
      fire && held_ff |=> $stable(clock_ff) && $stable(timer_ff) && $stable(mode_ff))
      else $error("held tick changed clock, timer or mode");

   // any unheld tick marks the clock as started
   assert property (@(posedge clock) disable iff (reset)
      fire && !held_ff |=> started_ff)
      else $error("clock not started after unheld tick");

   // a waiting tick in the input register is neither lost nor altered
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(held_ff) && $stable(button_ff))
      else $error("pending tick dropped or overwritten");

   // state only moves when a tick is passed into it
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(prescale_ff) && $stable(clock_ff) && $stable(timer_ff))
      else $error("state changed without a tick");
`endif

endmodule

[tb/fcc_checker.sv]
// ----------------------------------------------------------------------------
// fcc_checker
// watches the tick, result and register channels of the frame clock and
// chronometer, predicts every reading and compares it field by field
// ----------------------------------------------------------------------------
module fcc_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_held,
   input  logic                            req_button_pressed,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [fcc_pkg::HOUR_BITS-1:0]   rsp_clock_hours,
   input  logic [fcc_pkg::MIN_BITS-1:0]    rsp_clock_minutes,
   input  logic [fcc_pkg::SEC_BITS-1:0]    rsp_clock_seconds,
   input  logic [fcc_pkg::HOUR_BITS-1:0]   rsp_timer_hours,
   input  logic [fcc_pkg::MIN_BITS-1:0]    rsp_timer_minutes,
   input  logic [fcc_pkg::SEC_BITS-1:0]    rsp_timer_seconds,
   input  logic [1:0]                      rsp_timer_mode,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [fcc_pkg::DATA_BITS-1:0]   csr_wdata,
   output int                              fault_count,
   output int                              readings_due
);
   timeunit 1ns;
   timeprecision 1ps;

   import fcc_pkg::*;

   typedef struct packed {
      hms_type    tod;
      hms_type    chrono;
      logic [1:0] mode;
   } reading_type;

   // register copies
   logic [TPS_BITS-1:0] ticks_per_sec;
   hms_type             start_hms;

   // predicted block state
   tick_type    phase_ctr;
   tick_type    sec_prescale;
   hms_type     tod;
   hms_type     chrono;
   logic [1:0]  chrono_mode;
   logic        tod_loaded;

   reading_type expected_readings[$];
   int          faults = 0;

   assign fault_count = faults;

   initial readings_due = 0;

   function automatic tick_type wrap_step(input tick_type v);
      tick_type n;
      n = v + 1'b1;
      return (n >= ticks_per_sec) ? '0 : n;
   endfunction

   // one second on, carrying through minutes and hours
   function automatic hms_type hms_tick(input hms_type t);
      hms_type r;
      r = t;
      if (t.seconds < 59) begin
         r.seconds = t.seconds + 1'b1;
      end else begin
         r.seconds = '0;
         if (t.minutes < 59) begin
            r.minutes = t.minutes + 1'b1;
         end else begin
            r.minutes = '0;
            r.hours   = (t.hours < 23) ? t.hours + 1'b1 : '0;
         end
      end
      return r;
   endfunction

   function automatic reading_type advance_frame(input logic held, input logic button);
      reading_type r;
      phase_ctr = wrap_step(phase_ctr);
      if (!held) begin
         if (!tod_loaded) begin
            tod        = start_hms;
            tod_loaded = 1'b1;
         end
         if (button) begin
            if (chrono_mode == MODE_FORWARDS) begin
               chrono_mode    = MODE_BACKWARDS;
               chrono.minutes = '0;
               chrono.hours   = '0;
            end else if (chrono_mode != MODE_BACKWARDS) begin
               chrono_mode = MODE_FORWARDS;
            end
         end
         // countdown never borrows, it parks at zero
         if (chrono_mode == MODE_BACKWARDS) begin
            if (chrono.seconds <= 1) begin
               chrono.seconds = '0;
               chrono_mode    = MODE_STOPPED;
            end else if (phase_ctr != '0) begin
               chrono.seconds = chrono.seconds - 1'b1;
            end
         end
         sec_prescale = wrap_step(sec_prescale);
         if (sec_prescale == '0) begin
            if (chrono_mode == MODE_FORWARDS) chrono = hms_tick(chrono);
            tod = hms_tick(tod);
         end
      end
      r.tod    = tod;
      r.chrono = chrono;
      r.mode   = chrono_mode;
      return r;
   endfunction

   task automatic compare_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin
      reading_type want;
      int          delta;
      if (reset) begin
         ticks_per_sec = TPS_RESET;
         start_hms     = '0;
         phase_ctr     = '0;
         sec_prescale  = '0;
         tod           = '0;
         chrono        = '0;
         chrono_mode   = MODE_FORWARDS;
         tod_loaded    = 1'b0;
         expected_readings.delete();
         readings_due <= 0;
      end else begin
         delta = 0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TICKS_PER_SECOND: ticks_per_sec     = csr_wdata[TPS_BITS-1:0];
               REG_START_HOURS:      start_hms.hours   = csr_wdata[HOUR_BITS-1:0];
               REG_START_MINUTES:    start_hms.minutes = csr_wdata[MIN_BITS-1:0];
               REG_START_SECONDS:    start_hms.seconds = csr_wdata[SEC_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: result with no tick outstanding, expected none, actual %0d:%0d:%0d",
                        $time, rsp_clock_hours, rsp_clock_minutes, rsp_clock_seconds);
               faults++;
            end else begin
               want  = expected_readings.pop_front();
               delta = delta - 1;
               compare_field("clock_hours",   int'(want.tod.hours),
                             int'(rsp_clock_hours));
               compare_field("clock_minutes", int'(want.tod.minutes),
                             int'(rsp_clock_minutes));
               compare_field("clock_seconds", int'(want.tod.seconds),
                             int'(rsp_clock_seconds));
               compare_field("timer_hours",   int'(want.chrono.hours),
                             int'(rsp_timer_hours));
               compare_field("timer_minutes", int'(want.chrono.minutes),
                             int'(rsp_timer_minutes));
               compare_field("timer_seconds", int'(want.chrono.seconds),
                             int'(rsp_timer_seconds));
               compare_field("timer_mode",    int'(want.mode),
                             int'(rsp_timer_mode));
            end
         end
         if (req_valid && req_ready) begin
            expected_readings.push_back(advance_frame(req_held, req_button_pressed));
            delta = delta + 1;
         end
         readings_due <= readings_due + delta;
      end
   end

endmodule

[tb/frame_clock_and_chronometer_tb.sv]
// ----------------------------------------------------------------------------
// frame_clock_and_chronometer_tb
// drives frame ticks and register writes into the clock and chronometer
// ----------------------------------------------------------------------------
// A short directed run covers held ticks before the start time is loaded,
// out-of-range start values carrying through every field, each button press
// in each timer mode and the countdown parking at zero. Random ticks then
// run under several tick rates, from zero to the largest, with bursts of
// idling on both channels. The checker beside the block predicts and
// compares every reading; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------
module frame_clock_and_chronometer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fcc_pkg::*;

   // directed ticks, bit i is tick i
   localparam int        DIRECTED_TICKS  = 24;
   localparam bit [23:0] DIRECTED_HELD   = 24'h840007;
   localparam bit [23:0] DIRECTED_BUTTON = 24'h5C1804;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_held = 1'b0;
   logic                   req_button_pressed = 1'b0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [HOUR_BITS-1:0]   rsp_clock_hours;
   logic [MIN_BITS-1:0]    rsp_clock_minutes;
   logic [SEC_BITS-1:0]    rsp_clock_seconds;
   logic [HOUR_BITS-1:0]   rsp_timer_hours;
   logic [MIN_BITS-1:0]    rsp_timer_minutes;
   logic [SEC_BITS-1:0]    rsp_timer_seconds;
   logic [1:0]             rsp_timer_mode;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [1:0]             csr_index = REG_TICKS_PER_SECOND;
   logic [DATA_BITS-1:0]   csr_wdata = '0;

   int                     fault_count;
   int                     readings_due;

   // sender gap switch, and the receiver's quiet flag for the closing stretch
   bit                     sender_gaps = 1'b0;
   logic                   rsp_calm = 1'b0;

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   frame_clock_and_chronometer DUT (.*);

   fcc_checker checker_inst (.*);

   // ---------------------------------------------------------------------
   // result side: ready drops in random bursts, and whole
   // stretches go by with no stalls at all
   // ---------------------------------------------------------------------
   int   stall_left = 0;
   int   beat = 0;
   logic rsp_gaps = 1'b1;

   always @(posedge clock) begin
      beat <= beat + 1;
      if (beat % 100 == 0) rsp_gaps <= ($urandom_range(0, 2) != 0);
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!rsp_calm && rsp_gaps && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // tick side
   // ---------------------------------------------------------------------

   // one tick transfer; valid stays high into the next tick unless a gap
   // is taken first
   task automatic send_tick(input logic held, input logic button);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_held           <= held;
      req_button_pressed <= button;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and wait until every reading has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (readings_due != 0);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // all four registers, back to back, only while the block is idle
   task automatic load_settings(input logic [DATA_BITS-1:0] tps,
                                input logic [DATA_BITS-1:0] hours,
                                input logic [DATA_BITS-1:0] minutes,
                                input logic [DATA_BITS-1:0] seconds);
      write_reg(REG_TICKS_PER_SECOND, tps);
      write_reg(REG_START_HOURS, hours);
      write_reg(REG_START_MINUTES, minutes);
      write_reg(REG_START_SECONDS, seconds);
      csr_valid <= 1'b0;
   endtask

   // random ticks: mostly unheld, button now and then so the timer gets
   // time to build up seconds before a countdown
   task automatic random_ticks(input int count, input bit gaps);
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) sender_gaps = gaps && ($urandom_range(0, 3) != 0);
         send_tick($urandom_range(0, 4) == 0, $urandom_range(0, 15) == 0);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // start time all ones in every field: loaded as written, and the
      // first second carries through seconds, minutes and hours to zero
      load_settings(8'd2, 8'hFF, 8'hFF, 8'hFF);

      // directed: held ticks before the start load, button ignored while
      // held, forwards to backwards, press while counting down, countdown
      // to stopped, stopped to forwards, forwards to backwards parking straight at zero
      sender_gaps = 1'b1;
      for (int i = 0; i < DIRECTED_TICKS; i++) begin
         send_tick(DIRECTED_HELD[i], DIRECTED_BUTTON[i]);
      end
      drain();

      // zero ticks per second: every unheld tick is a second
      load_settings(8'd0, 8'd0, 8'd0, 8'd0);
      random_ticks(350, 1'b1);
      drain();

      // widest wrap value, seconds come slowly
      load_settings(8'hFF, 8'd23, 8'd59, 8'd59);
      random_ticks(300, 1'b1);
      drain();

      // one tick per second, phase always zero so countdown only parks
      load_settings(8'd1, DATA_BITS'($urandom_range(0, 255)),
                    DATA_BITS'($urandom_range(0, 255)),
                    DATA_BITS'($urandom_range(0, 255)));
      random_ticks(300, 1'b1);
      drain();

      // odd rate; the sender waits for the block to empty halfway through
      load_settings(8'd7, 8'd12, 8'd30, 8'd45);
      random_ticks(250, 1'b1);
      drain();
      random_ticks(250, 1'b1);
      drain();

      // closing stretch with no idling on either side
      load_settings(8'd3, 8'd1, 8'd2, 8'd3);
      rsp_calm <= 1'b1;
      random_ticks(400, 1'b0);
      drain();

      // allow for the pipeline before the verdict
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog, several times the slowest correct run
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
